// ===== sv/qsd_pkg.sv =====
`default_nettype none
// ============================================================================
// qsd_pkg
// Shared types and constants of the swap delta evaluator.
// ============================================================================
package qsd_pkg;

    // problem dimensions
    localparam int N_MAX   = 64;
    localparam int IDX_W   = $clog2(N_MAX);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int ENTRY_W = 16;
    localparam int SIZE_W  = 7;

    // arithmetic widths: a term factor sums up to four entries with signs
    localparam int SUM_W  = ENTRY_W + 3;
    localparam int PROD_W = 2 * SUM_W;
    localparam int OUT_W  = 48;
    localparam int ACC_W  = OUT_W + 2;

    // stream widths
    localparam int MODE_W      = 3;
    localparam int IN_TDATA_W  = 4 * IDX_W + ENTRY_W + OUT_W;
    localparam int OUT_TDATA_W = OUT_W;

    // item kinds carried in tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_FLOW  = 3'd0,
        MODE_LOAD_DIST  = 3'd1,
        MODE_LOAD_PLACE = 3'd2,
        MODE_SWAP       = 3'd3,
        MODE_FULL_DELTA = 3'd4,
        MODE_INCR_DELTA = 3'd5
    } mode_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic               f_we;
        logic               d_we;
        logic [ADDR_W-1:0]  m_waddr;
        logic [ENTRY_W-1:0] m_wdata;
        logic               p_we;
        logic [IDX_W-1:0]   p_waddr;
        logic [IDX_W-1:0]   p_wdata;
        logic [ADDR_W-1:0]  f_raddr;
        logic [ADDR_W-1:0]  d_raddr;
        logic [IDX_W-1:0]   p_raddr;
    } mem_req_t;

    // tag of one flow/distance read pair
    typedef struct packed {
        logic valid;
        logic neg;
        logic first;
        logic last;
        logic keep;
    } pair_t;

    // accumulator control
    typedef struct packed {
        logic acc_init;
        logic init_incr;
    } mac_ctl_t;

    // sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic out_load;
    } seq_stat_t;

endpackage
`default_nettype wire

// ===== sv/qsd_mem.sv =====
`default_nettype none
// ============================================================================
// qsd_mem
// Flow, distance and placement memories, one write and one registered read
// port each.
// ============================================================================
module qsd_mem (
    input  logic                              clk,
    input  qsd_pkg::mem_req_t                 req,
    output logic [qsd_pkg::ENTRY_W-1:0]       f_rdata,
    output logic [qsd_pkg::ENTRY_W-1:0]       d_rdata,
    output logic [qsd_pkg::IDX_W-1:0]         p_rdata
);
    import qsd_pkg::*;

    logic [ENTRY_W-1:0] flow_mem  [N_MAX*N_MAX];
    logic [ENTRY_W-1:0] dist_mem  [N_MAX*N_MAX];
    logic [IDX_W-1:0]   place_mem [N_MAX];

    logic [ENTRY_W-1:0] f_rdata_reg;
    logic [ENTRY_W-1:0] d_rdata_reg;
    logic [IDX_W-1:0]   p_rdata_reg;

    // flow matrix
    always_ff @(posedge clk)
    begin
        if (req.f_we)
        begin
            flow_mem[req.m_waddr] <= req.m_wdata;
        end
        f_rdata_reg <= flow_mem[req.f_raddr];
    end

    // distance matrix
    always_ff @(posedge clk)
    begin
        if (req.d_we)
        begin
            dist_mem[req.m_waddr] <= req.m_wdata;
        end
        d_rdata_reg <= dist_mem[req.d_raddr];
    end

    // placement: facility to location
    always_ff @(posedge clk)
    begin
        if (req.p_we)
        begin
            place_mem[req.p_waddr] <= req.p_wdata;
        end
        p_rdata_reg <= place_mem[req.p_raddr];
    end

    assign f_rdata = f_rdata_reg;
    assign d_rdata = d_rdata_reg;
    assign p_rdata = p_rdata_reg;

endmodule
`default_nettype wire

// ===== sv/qsd_mac.sv =====
`default_nettype none
// ============================================================================
// qsd_mac
// Shared multiply-accumulate unit: sums signed entries into two factors,
// multiplies them and adds the product to the delta accumulator.
// ============================================================================
module qsd_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qsd_pkg::pair_t                    pair,
    input  qsd_pkg::mac_ctl_t                 ctl,
    input  logic signed [qsd_pkg::OUT_W-1:0]  prior_delta,
    input  logic [qsd_pkg::ENTRY_W-1:0]       f_rdata,
    input  logic [qsd_pkg::ENTRY_W-1:0]       d_rdata,
    output logic [qsd_pkg::OUT_W-1:0]         cost_delta,
    output logic                              busy
);
    import qsd_pkg::*;

    pair_t                    pair_reg;
    logic signed [SUM_W-1:0]  fsum_reg;
    logic signed [SUM_W-1:0]  fsum_next;
    logic signed [SUM_W-1:0]  dsum_reg;
    logic signed [SUM_W-1:0]  dsum_next;
    logic                     term_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [SUM_W-1:0]  f_ext;
    logic signed [SUM_W-1:0]  d_ext;
    logic signed [SUM_W-1:0]  f_base;
    logic signed [SUM_W-1:0]  d_base;

    // tag is registered once, so it lines up with the registered memory read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg       <= '0;
            term_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            pair_reg       <= pair;
            term_valid_reg <= pair_reg.valid & pair_reg.last & pair_reg.keep;
            prod_valid_reg <= term_valid_reg;
        end
    end

    // factor sums
    always_comb
    begin
        f_ext     = $signed({{(SUM_W-ENTRY_W){1'b0}}, f_rdata});
        d_ext     = $signed({{(SUM_W-ENTRY_W){1'b0}}, d_rdata});
        f_base    = pair_reg.first ? '0 : fsum_reg;
        d_base    = pair_reg.first ? '0 : dsum_reg;
        fsum_next = fsum_reg;
        dsum_next = dsum_reg;
        if (pair_reg.valid)
        begin
            fsum_next = pair_reg.neg ? f_base - f_ext : f_base + f_ext;
            dsum_next = pair_reg.neg ? d_base - d_ext : d_base + d_ext;
        end
    end

    // accumulator
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.acc_init)
        begin
            acc_next = ctl.init_incr ? ACC_W'(prior_delta) : '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        fsum_reg <= fsum_next;
        dsum_reg <= dsum_next;
        prod_reg <= fsum_reg * dsum_reg;
        acc_reg  <= acc_next;
    end

    // saturate to the output range
    always_comb
    begin
        if (acc_reg[ACC_W-1:OUT_W-1] == '0 || acc_reg[ACC_W-1:OUT_W-1] == '1)
        begin
            cost_delta = acc_reg[OUT_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            cost_delta = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            cost_delta = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    assign busy = pair_reg.valid | term_valid_reg | prod_valid_reg;

endmodule
`default_nettype wire

// ===== sv/qsd_seq.sv =====
`default_nettype none
// ============================================================================
// qsd_seq
// Sequencer: takes transactions, looks up placements, walks the read pairs
// of each delta term and hands the finished delta to the output register.
// ============================================================================
module qsd_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [qsd_pkg::MODE_W-1:0]        mode,
    input  logic [qsd_pkg::IDX_W-1:0]         first_index,
    input  logic [qsd_pkg::IDX_W-1:0]         second_index,
    input  logic [qsd_pkg::IDX_W-1:0]         moved_first,
    input  logic [qsd_pkg::IDX_W-1:0]         moved_second,
    input  logic [qsd_pkg::ENTRY_W-1:0]       entry_value,
    input  logic [qsd_pkg::SIZE_W-1:0]        problem_size,
    input  logic                              out_free,
    input  logic [qsd_pkg::IDX_W-1:0]         place_rdata,
    output logic                              in_ready,
    output qsd_pkg::mem_req_t                 mem_req,
    output qsd_pkg::pair_t                    pair,
    output qsd_pkg::mac_ctl_t                 mac_ctl,
    output qsd_pkg::seq_stat_t                stat
);
    import qsd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FETCH = 6'b000010,
        ST_SWAP  = 6'b000100,
        ST_ISSUE = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    localparam logic [2:0] FETCH_LAST = 3'd4;
    localparam logic [2:0] DRAIN_LAST = 3'd2;

    state_t             state_reg;
    state_t             state_next;
    logic [2:0]         cnt_reg;
    logic [2:0]         cnt_next;
    logic [1:0]         ph_reg;
    logic [1:0]         ph_next;
    logic               grp_reg;
    logic               grp_next;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   k_next;
    mode_t              mode_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   r_reg;
    logic [IDX_W-1:0]   s_reg;
    logic [IDX_W-1:0]   pl_reg [4];
    logic [IDX_W-1:0]   pk_reg;
    logic [IDX_W-1:0]   pk;
    logic [2:0]         cnt_dec;
    logic [SIZE_W-1:0]  n_eff;
    logic               accept;
    logic               is_full;
    logic [IDX_W-1:0]   f_row;
    logic [IDX_W-1:0]   f_col;
    logic [IDX_W-1:0]   d_row;
    logic [IDX_W-1:0]   d_col;
    logic [IDX_W-1:0]   pi;
    logic [IDX_W-1:0]   pj;
    logic [IDX_W-1:0]   pr;
    logic [IDX_W-1:0]   ps;

    assign accept  = in_valid & (state_reg == ST_IDLE);
    assign is_full = (mode_reg == MODE_FULL_DELTA);
    assign n_eff   = (problem_size > SIZE_W'(N_MAX)) ? SIZE_W'(N_MAX) : problem_size;
    assign cnt_dec = cnt_reg - 3'd1;
    assign pi      = pl_reg[0];
    assign pj      = pl_reg[1];
    assign pr      = pl_reg[2];
    assign ps      = pl_reg[3];
    assign pk      = (ph_reg == 2'd0) ? place_rdata : pk_reg;

    // state transitions
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ph_next    = ph_reg;
        grp_next   = grp_reg;
        k_next     = k_reg;
        stat       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                if (accept)
                begin
                    case (mode_t'(mode))
                        MODE_SWAP, MODE_FULL_DELTA, MODE_INCR_DELTA:
                        begin
                            state_next = ST_FETCH;
                            cnt_next   = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == FETCH_LAST)
                begin
                    cnt_next   = '0;
                    ph_next    = '0;
                    grp_next   = 1'b0;
                    k_next     = '0;
                    state_next = (mode_reg == MODE_SWAP) ? ST_SWAP : ST_ISSUE;
                end
            end
            ST_SWAP:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg[0])
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_ISSUE:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    if (!grp_reg)
                    begin
                        grp_next = 1'b1;
                        k_next   = '0;
                        if (is_full && n_eff == '0)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    else if (!is_full || {1'b0, k_reg} == n_eff - SIZE_W'(1))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        k_next = k_reg + IDX_W'(1);
                    end
                    if (state_next == ST_DRAIN)
                    begin
                        cnt_next = '0;
                    end
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == DRAIN_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    stat.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ph_reg    <= '0;
            grp_reg   <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ph_reg    <= ph_next;
            grp_reg   <= grp_next;
            k_reg     <= k_next;
        end
    end

    // transaction fields and looked-up locations
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_t'(mode);
            i_reg    <= first_index;
            j_reg    <= second_index;
            r_reg    <= moved_first;
            s_reg    <= moved_second;
        end
        if (state_reg == ST_FETCH && cnt_reg != '0)
        begin
            pl_reg[cnt_dec[1:0]] <= place_rdata;
        end
        if (state_reg == ST_ISSUE && ph_reg == 2'd0)
        begin
            pk_reg <= place_rdata;
        end
    end

    // read pair addresses: flow row/col, distance row/col by location
    always_comb
    begin
        f_row = i_reg;
        f_col = i_reg;
        d_row = pj;
        d_col = pj;
        if (is_full && !grp_reg)
        begin
            case (ph_reg)
                2'd0:    begin f_row = i_reg; f_col = i_reg; d_row = pj; d_col = pj; end
                2'd1:    begin f_row = j_reg; f_col = j_reg; d_row = pi; d_col = pi; end
                2'd2:    begin f_row = i_reg; f_col = j_reg; d_row = pj; d_col = pi; end
                default: begin f_row = j_reg; f_col = i_reg; d_row = pi; d_col = pj; end
            endcase
        end
        else if (is_full)
        begin
            case (ph_reg)
                2'd0:    begin f_row = k_reg; f_col = i_reg; d_row = pk; d_col = pj; end
                2'd1:    begin f_row = k_reg; f_col = j_reg; d_row = pk; d_col = pi; end
                2'd2:    begin f_row = i_reg; f_col = k_reg; d_row = pj; d_col = pk; end
                default: begin f_row = j_reg; f_col = k_reg; d_row = pi; d_col = pk; end
            endcase
        end
        else if (!grp_reg)
        begin
            case (ph_reg)
                2'd0:    begin f_row = r_reg; f_col = i_reg; d_row = ps; d_col = pi; end
                2'd1:    begin f_row = r_reg; f_col = j_reg; d_row = ps; d_col = pj; end
                2'd2:    begin f_row = s_reg; f_col = j_reg; d_row = pr; d_col = pj; end
                default: begin f_row = s_reg; f_col = i_reg; d_row = pr; d_col = pi; end
            endcase
        end
        else
        begin
            case (ph_reg)
                2'd0:    begin f_row = i_reg; f_col = r_reg; d_row = pi; d_col = ps; end
                2'd1:    begin f_row = j_reg; f_col = r_reg; d_row = pj; d_col = ps; end
                2'd2:    begin f_row = j_reg; f_col = s_reg; d_row = pj; d_col = pr; end
                default: begin f_row = i_reg; f_col = s_reg; d_row = pi; d_col = pr; end
            endcase
        end
    end

    // memory requests: loads on accept, swap write-back, lookups
    always_comb
    begin
        mem_req         = '0;
        mem_req.f_we    = accept & (mode_t'(mode) == MODE_LOAD_FLOW);
        mem_req.d_we    = accept & (mode_t'(mode) == MODE_LOAD_DIST);
        mem_req.m_waddr = {first_index, second_index};
        mem_req.m_wdata = entry_value;
        mem_req.p_we    = accept & (mode_t'(mode) == MODE_LOAD_PLACE);
        mem_req.p_waddr = first_index;
        mem_req.p_wdata = entry_value[IDX_W-1:0];
        mem_req.f_raddr = {f_row, f_col};
        mem_req.d_raddr = {d_row, d_col};
        mem_req.p_raddr = grp_reg ? k_reg + IDX_W'(1) : '0;
        if (state_reg == ST_FETCH)
        begin
            case (cnt_reg[1:0])
                2'd0:    mem_req.p_raddr = i_reg;
                2'd1:    mem_req.p_raddr = j_reg;
                2'd2:    mem_req.p_raddr = r_reg;
                default: mem_req.p_raddr = s_reg;
            endcase
        end
        if (state_reg == ST_SWAP)
        begin
            mem_req.p_we    = 1'b1;
            mem_req.p_waddr = cnt_reg[0] ? j_reg : i_reg;
            mem_req.p_wdata = cnt_reg[0] ? pi : pj;
        end
    end

    // pair tag: even pairs add, odd pairs subtract
    always_comb
    begin
        pair.valid = (state_reg == ST_ISSUE);
        pair.neg   = ph_reg[0];
        pair.first = is_full ? !ph_reg[0] : (ph_reg == 2'd0);
        pair.last  = is_full ? ph_reg[0] : (ph_reg == 2'd3);
        pair.keep  = (is_full && grp_reg) ? (k_reg != i_reg && k_reg != j_reg) : 1'b1;
    end

    assign mac_ctl.acc_init  = accept;
    assign mac_ctl.init_incr = (mode_t'(mode) == MODE_INCR_DELTA);
    assign in_ready          = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

// ===== sv/qap_swap_delta_evaluator.sv =====
`default_nettype none
// ============================================================================
// qap_swap_delta_evaluator
// Quadratic assignment swap delta evaluator: flow, distance and placement
// memories with full and incremental swap cost deltas.
// ============================================================================
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tuser mode, tdata indices/value/prior
//  m_*       out        m_tvalid/m_tready   tdata cost_delta
//  apb       in         psel/penable        problem_size at byte address 0
//
//  loads are written as they are taken; a full delta walks every facility in use;
//  delta terms make one flow and one distance read per cycle through the single
//  read port of each matrix memory.
//  rst_n clears control state only; memories hold nothing valid until loaded.
//  a finished delta waits in the output register while the next transaction
//  is taken; the sequencer stalls in its last state only if that register is full.
// ============================================================================
module qap_swap_delta_evaluator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // mode [2:0]
    input  logic [qsd_pkg::MODE_W-1:0]           s_tuser,
    // first_index [5:0], second_index [11:6], moved_first [17:12],
    // moved_second [23:18], entry_value [39:24], prior_delta [87:40]
    input  logic [qsd_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // cost_delta [47:0]
    output logic [qsd_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import qsd_pkg::*;

    localparam logic REG_PROBLEM_SIZE = 1'b0;
    localparam int   IDX0 = 0;
    localparam int   IDX1 = IDX0 + IDX_W;
    localparam int   IDX2 = IDX1 + IDX_W;
    localparam int   IDX3 = IDX2 + IDX_W;
    localparam int   VAL0 = IDX3 + IDX_W;
    localparam int   PRI0 = VAL0 + ENTRY_W;

    logic [SIZE_W-1:0]  size_reg;
    logic               cfg_we;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_valid_reg;
    logic               out_free;
    mem_req_t           mem_req;
    pair_t              pair;
    mac_ctl_t           mac_ctl;
    seq_stat_t          stat;
    logic [ENTRY_W-1:0] f_rdata;
    logic [ENTRY_W-1:0] d_rdata;
    logic [IDX_W-1:0]   p_rdata;
    logic [OUT_W-1:0]   cost_delta;
    logic               mac_busy;

    // configuration register
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_PROBLEM_SIZE);
    assign prdata = (paddr[2] == REG_PROBLEM_SIZE) ? {{(32-SIZE_W){1'b0}}, size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(N_MAX);
        end
        else if (cfg_we)
        begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // sequencer
    qsd_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .mode         (s_tuser),
        .first_index  (s_tdata[IDX1-1:IDX0]),
        .second_index (s_tdata[IDX2-1:IDX1]),
        .moved_first  (s_tdata[IDX3-1:IDX2]),
        .moved_second (s_tdata[VAL0-1:IDX3]),
        .entry_value  (s_tdata[PRI0-1:VAL0]),
        .problem_size (size_reg),
        .out_free     (out_free),
        .place_rdata  (p_rdata),
        .in_ready     (s_tready),
        .mem_req      (mem_req),
        .pair         (pair),
        .mac_ctl      (mac_ctl),
        .stat         (stat)
    );

    // matrix and placement memories
    qsd_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .f_rdata (f_rdata),
        .d_rdata (d_rdata),
        .p_rdata (p_rdata)
    );

    // shared multiply-accumulate unit
    qsd_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .pair        (pair),
        .ctl         (mac_ctl),
        .prior_delta ($signed(s_tdata[PRI0+OUT_W-1:PRI0])),
        .f_rdata     (f_rdata),
        .d_rdata     (d_rdata),
        .cost_delta  (cost_delta),
        .busy        (mac_busy)
    );

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.out_load)
        begin
            out_data_reg <= cost_delta;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while pending");

    // the arithmetic pipeline is empty whenever a transaction can be taken
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mac_busy)
        else $error("arithmetic pipeline busy while idle");

    // a delta transaction takes the block out of idle
    a_delta_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == MODE_FULL_DELTA || s_tuser == MODE_INCR_DELTA))
        |=> !s_tready)
        else $error("delta transaction did not start the sequencer");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_qap_swap_delta_evaluator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_qap_swap_delta_evaluator
// Self-checking testbench for the swap delta evaluator. A short table of
// directed transactions comes first. The flow, distance and placement
// memories are then filled completely. Random phases follow, each at one
// problem size; they mix loads, swaps, full deltas and move sequences
// (full delta, swap, incremental delta that carries the earlier delta).
// Each delta is checked against a cost predictor that keeps its own copy of
// the memories, and both stream sides stall at random.
// ============================================================================
module tb_qap_swap_delta_evaluator;
    import qsd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 6;
    localparam int DRAIN_CYCLES  = 4 * N_MAX + 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 45;
    localparam int PHASES        = 9;
    localparam int HOLD_PHASE    = 6;
    localparam int NO_IDLE_PHASE = 7;
    localparam int DIR_ROWS      = 25;
    localparam longint TIMEOUT_NS = 10_000_000;

    // register map and spare item kinds
    localparam logic [2:0] REG_PROBLEM_SIZE = 3'd0;
    localparam logic [2:0] REG_UNMAPPED     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    // saturation bounds of cost_delta
    localparam logic [OUT_W-1:0] OUT_HI = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_LO = {1'b1, {(OUT_W-1){1'b0}}};
    localparam longint DELTA_HI = longint'(OUT_HI);
    localparam longint DELTA_LO = longint'($signed(OUT_LO));

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   row_i;
        logic [IDX_W-1:0]   col_j;
        logic [IDX_W-1:0]   mov_r;
        logic [IDX_W-1:0]   mov_s;
        logic [ENTRY_W-1:0] value;
        logic [OUT_W-1:0]   prior;
    } qap_item_t;

    typedef struct packed {
        qap_item_t        item;
        logic             lit_en;
        logic [OUT_W-1:0] lit;
    } dir_vec_t;

    logic                   clk;
    logic                   rst_n;
    logic [MODE_W-1:0]      s_tuser;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    // predictor copy of the block state
    bit [ENTRY_W-1:0] flow_mem [N_MAX*N_MAX];
    bit [ENTRY_W-1:0] dist_mem [N_MAX*N_MAX];
    bit [IDX_W-1:0]   loc_of [N_MAX];
    bit [SIZE_W-1:0]  size_reg;

    logic [OUT_W-1:0] delta_expected_q [$];
    int errors;
    int items_sent;
    bit idle_on;
    bit hold_go;
    bit hold_off;

    qap_swap_delta_evaluator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("qap_swap_delta_evaluator verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, wanted %h (t=%0t)", what, got, want, $time);
        errors++;
    endtask

    // cost predictor
    function automatic longint flow_at(input int a, input int b);
        return longint'(flow_mem[a * N_MAX + b]);
    endfunction

    // distance between the locations of facilities a and b
    function automatic longint dist_at(input int a, input int b);
        return longint'(dist_mem[int'(loc_of[a]) * N_MAX + int'(loc_of[b])]);
    endfunction

    function automatic longint full_swap_delta(input int i, input int j);
        int n;
        longint d;
        n = (int'(size_reg) > N_MAX) ? N_MAX : int'(size_reg);
        d = (flow_at(i, i) - flow_at(j, j)) * (dist_at(j, j) - dist_at(i, i))
          + (flow_at(i, j) - flow_at(j, i)) * (dist_at(j, i) - dist_at(i, j));
        for (int k = 0; k < n; k++)
            if (k != i && k != j)
                d += (flow_at(k, i) - flow_at(k, j)) * (dist_at(k, j) - dist_at(k, i))
                   + (flow_at(i, k) - flow_at(j, k)) * (dist_at(j, k) - dist_at(i, k));
        return d;
    endfunction

    function automatic longint incr_swap_delta(input int i, input int j, input int r,
                                               input int s, input longint prior);
        longint d;
        d = prior;
        d += (flow_at(r, i) - flow_at(r, j) + flow_at(s, j) - flow_at(s, i))
           * (dist_at(s, i) - dist_at(s, j) + dist_at(r, j) - dist_at(r, i));
        d += (flow_at(i, r) - flow_at(j, r) + flow_at(j, s) - flow_at(i, s))
           * (dist_at(i, s) - dist_at(j, s) + dist_at(j, r) - dist_at(i, r));
        return d;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_delta(input longint d);
        if (d > DELTA_HI)
            return OUT_HI;
        if (d < DELTA_LO)
            return OUT_LO;
        return d[OUT_W-1:0];
    endfunction

    // apply one transaction to the predictor state, return 1 when it yields a delta
    function automatic bit predict_item(input qap_item_t it, output logic [OUT_W-1:0] res);
        int i;
        int j;
        bit [IDX_W-1:0] held;
        i = int'(it.row_i);
        j = int'(it.col_j);
        res = '0;
        case (it.mode)
            MODE_LOAD_FLOW:  flow_mem[i * N_MAX + j] = it.value;
            MODE_LOAD_DIST:  dist_mem[i * N_MAX + j] = it.value;
            MODE_LOAD_PLACE: loc_of[i] = it.value[IDX_W-1:0];
            MODE_SWAP:
            begin
                held      = loc_of[i];
                loc_of[i] = loc_of[j];
                loc_of[j] = held;
            end
            MODE_FULL_DELTA:
            begin
                res = clamp_delta(full_swap_delta(i, j));
                return 1'b1;
            end
            MODE_INCR_DELTA:
            begin
                res = clamp_delta(incr_swap_delta(i, j, int'(it.mov_r), int'(it.mov_s),
                                                  longint'($signed(it.prior))));
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic dir_vec_t dir_row(input logic [MODE_W-1:0] m, input int i, input int j,
                                         input int r, input int s, input logic [ENTRY_W-1:0] v,
                                         input logic [OUT_W-1:0] p, input bit lit_en,
                                         input logic [OUT_W-1:0] lit);
        dir_vec_t row;
        row.item.mode  = m;
        row.item.row_i = IDX_W'(i);
        row.item.col_j = IDX_W'(j);
        row.item.mov_r = IDX_W'(r);
        row.item.mov_s = IDX_W'(s);
        row.item.value = v;
        row.item.prior = p;
        row.lit_en     = lit_en;
        row.lit        = lit;
        return row;
    endfunction

    // random transaction with every field random, kind weighted toward deltas
    function automatic qap_item_t random_item();
        qap_item_t it;
        logic [63:0] wide;
        int pick;
        wide     = {$urandom, $urandom};
        it.row_i = IDX_W'($urandom_range(0, N_MAX - 1));
        it.col_j = IDX_W'($urandom_range(0, N_MAX - 1));
        it.mov_r = IDX_W'($urandom_range(0, N_MAX - 1));
        it.mov_s = IDX_W'($urandom_range(0, N_MAX - 1));
        case ($urandom_range(9))
            0:       it.value = '0;
            1:       it.value = '1;
            default: it.value = ENTRY_W'($urandom);
        endcase
        case ($urandom_range(5))
            0:       it.prior = OUT_HI;
            1:       it.prior = OUT_LO;
            2:       it.prior = OUT_HI - OUT_W'($urandom_range(0, 1 << 24));
            3:       it.prior = OUT_LO + OUT_W'($urandom_range(0, 1 << 24));
            4:       it.prior = OUT_W'(longint'($urandom_range(0, 2_000_000)) - 1_000_000);
            default: it.prior = wide[OUT_W-1:0];
        endcase
        pick = $urandom_range(99);
        if (pick < 10)
            it.mode = MODE_LOAD_FLOW;
        else if (pick < 20)
            it.mode = MODE_LOAD_DIST;
        else if (pick < 26)
            it.mode = MODE_LOAD_PLACE;
        else if (pick < 36)
            it.mode = MODE_SWAP;
        else if (pick < 38)
            it.mode = MODE_RSVD6;
        else if (pick < 40)
            it.mode = MODE_RSVD7;
        else if (pick < 70)
            it.mode = MODE_FULL_DELTA;
        else
            it.mode = MODE_INCR_DELTA;
        return it;
    endfunction

    // offer one transaction, wait for it to be taken, then predict it
    task automatic send_item(input qap_item_t it, input bit lit_en,
                             input logic [OUT_W-1:0] lit);
        logic [OUT_W-1:0] res;
        if (idle_on && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {it.prior, it.value, it.mov_s, it.mov_r, it.col_j, it.row_i};
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (predict_item(it, res))
            delta_expected_q.push_back(lit_en ? lit : res);
    endtask

    // full delta of i,j, swap of r,s, then incremental delta of i,j from the old delta
    task automatic send_move_sequence();
        qap_item_t it;
        logic [OUT_W-1:0] before_swap;
        int lim;
        int i;
        int j;
        int r;
        int s;
        lim = (size_reg >= 4 && int'(size_reg) <= N_MAX) ? int'(size_reg) : N_MAX;
        i = $urandom_range(0, lim - 1);
        j = $urandom_range(0, lim - 1);
        while (j == i)
            j = $urandom_range(0, lim - 1);
        r = $urandom_range(0, lim - 1);
        while (r == i || r == j)
            r = $urandom_range(0, lim - 1);
        s = $urandom_range(0, lim - 1);
        while (s == i || s == j || s == r)
            s = $urandom_range(0, lim - 1);
        before_swap = clamp_delta(full_swap_delta(i, j));

        it       = random_item();
        it.mode  = MODE_FULL_DELTA;
        it.row_i = IDX_W'(i);
        it.col_j = IDX_W'(j);
        send_item(it, 1'b0, '0);

        it       = random_item();
        it.mode  = MODE_SWAP;
        it.row_i = IDX_W'(r);
        it.col_j = IDX_W'(s);
        send_item(it, 1'b0, '0);

        it       = random_item();
        it.mode  = MODE_INCR_DELTA;
        it.row_i = IDX_W'(i);
        it.col_j = IDX_W'(j);
        it.mov_r = IDX_W'(r);
        it.mov_s = IDX_W'(s);
        it.prior = before_swap;
        send_item(it, 1'b0, '0);
    endtask

    // stop offering and let every outstanding delta arrive
    task automatic settle();
        s_tvalid <= 1'b0;
        while (delta_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == REG_PROBLEM_SIZE)
            size_reg = data[SIZE_W-1:0];
        @(posedge clk);
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            report_mismatch("problem_size readback", 64'(prdata), 64'(want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_problem_size(input int sz, input bit poke_unmapped);
        logic [31:0] word;
        settle();
        word = $urandom;
        word[SIZE_W-1:0] = SIZE_W'(sz);
        apb_write(REG_PROBLEM_SIZE, word);
        if (poke_unmapped)
            apb_write(REG_UNMAPPED, $urandom);
        apb_check(REG_PROBLEM_SIZE, 32'(size_reg));
    endtask

    // long receiver hold-off, so the block fills up and stalls its input
    initial
    begin
        hold_off = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result side: compare each transaction with the oldest expected delta
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (delta_expected_q.size() == 0)
                report_mismatch("cost_delta with nothing pending", 64'(m_tdata), '0);
            else
            begin
                want = delta_expected_q.pop_front();
                if (m_tdata !== want)
                    report_mismatch("cost_delta", 64'(m_tdata), 64'(want));
            end
        end
        m_tready <= !hold_off && !(idle_on && $urandom_range(99) < 20);
    end

    // main sequence
    initial
    begin
        dir_vec_t dir_tbl [DIR_ROWS];
        int sizes [PHASES];
        qap_item_t it;
        int goal;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = '0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        errors     = 0;
        items_sent = 0;
        idle_on    = 1'b1;
        hold_go    = 1'b0;
        size_reg   = SIZE_W'(N_MAX);

        // directed rows, run with two facilities in use
        dir_tbl[0]  = dir_row(MODE_LOAD_FLOW, 0, 0, 0, 0, 16'hFFFF, '0, 0, '0);
        dir_tbl[1]  = dir_row(MODE_LOAD_FLOW, 0, 1, 0, 0, 16'h0000, '0, 0, '0);
        dir_tbl[2]  = dir_row(MODE_LOAD_FLOW, 1, 0, 0, 0, 16'h0000, '0, 0, '0);
        dir_tbl[3]  = dir_row(MODE_LOAD_FLOW, 1, 1, 0, 0, 16'h0000, '0, 0, '0);
        dir_tbl[4]  = dir_row(MODE_LOAD_DIST, 0, 0, 0, 0, 16'h0000, '0, 0, '0);
        dir_tbl[5]  = dir_row(MODE_LOAD_DIST, 0, 1, 0, 0, 16'h0000, '0, 0, '0);
        dir_tbl[6]  = dir_row(MODE_LOAD_DIST, 1, 0, 0, 0, 16'h0000, '0, 0, '0);
        dir_tbl[7]  = dir_row(MODE_LOAD_DIST, 1, 1, 0, 0, 16'hFFFF, '0, 0, '0);
        // placement values wrap to a location index
        dir_tbl[8]  = dir_row(MODE_LOAD_PLACE, 0, 0, 0, 0, 16'hFFC0, '0, 0, '0);
        dir_tbl[9]  = dir_row(MODE_LOAD_PLACE, 1, 0, 0, 0, 16'h0041, '0, 0, '0);
        // largest entries on the diagonal
        dir_tbl[10] = dir_row(MODE_FULL_DELTA, 0, 1, 0, 0, '0, '0, 1, 48'h0000_FFFE_0001);
        // same facility twice
        dir_tbl[11] = dir_row(MODE_FULL_DELTA, 1, 1, 0, 0, '0, '0, 1, '0);
        // earlier move of a facility onto itself leaves the delta alone
        dir_tbl[12] = dir_row(MODE_INCR_DELTA, 0, 1, 0, 0, '0, OUT_HI, 1, OUT_HI);
        // negative saturation
        dir_tbl[13] = dir_row(MODE_INCR_DELTA, 0, 1, 0, 1, '0, OUT_LO, 1, OUT_LO);
        dir_tbl[14] = dir_row(MODE_INCR_DELTA, 0, 1, 0, 1, '0, OUT_HI, 0, '0);
        dir_tbl[15] = dir_row(MODE_SWAP, 0, 1, 0, 0, '0, '0, 0, '0);
        dir_tbl[16] = dir_row(MODE_FULL_DELTA, 0, 1, 0, 0, '0, '0, 0, '0);
        // spare kinds do nothing
        dir_tbl[17] = dir_row(MODE_RSVD6, 63, 63, 63, 63, '1, '1, 0, '0);
        dir_tbl[18] = dir_row(MODE_RSVD7, 0, 0, 0, 0, '0, '0, 0, '0);
        // top index of every memory
        dir_tbl[19] = dir_row(MODE_LOAD_FLOW, 63, 63, 0, 0, 16'hFFFF, '0, 0, '0);
        dir_tbl[20] = dir_row(MODE_LOAD_DIST, 63, 63, 0, 0, 16'hA5A5, '0, 0, '0);
        dir_tbl[21] = dir_row(MODE_LOAD_PLACE, 63, 0, 0, 0, 16'hFFFF, '0, 0, '0);
        dir_tbl[22] = dir_row(MODE_FULL_DELTA, 1, 0, 63, 63, 16'hFFFF, '1, 0, '0);
        dir_tbl[23] = dir_row(MODE_LOAD_FLOW, 1, 0, 0, 0, 16'h8001, '0, 0, '0);
        dir_tbl[24] = dir_row(MODE_INCR_DELTA, 1, 0, 1, 0, '0, '0, 0, '0);

        sizes = '{N_MAX, 127, 0, 1, 2, 3, 65, N_MAX, 0};
        sizes[PHASES-1] = $urandom_range(2, N_MAX);

        // reset
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        set_problem_size(2, 1'b0);
        foreach (dir_tbl[k])
            send_item(dir_tbl[k].item, dir_tbl[k].lit_en, dir_tbl[k].lit);
        settle();

        // fill every memory entry so no later read hits an unwritten one
        for (int a = 0; a < N_MAX; a++)
            for (int b = 0; b < N_MAX; b++)
            begin
                it       = random_item();
                it.mode  = MODE_LOAD_FLOW;
                it.row_i = IDX_W'(a);
                it.col_j = IDX_W'(b);
                send_item(it, 1'b0, '0);
            end
        for (int a = 0; a < N_MAX; a++)
            for (int b = 0; b < N_MAX; b++)
            begin
                it       = random_item();
                it.mode  = MODE_LOAD_DIST;
                it.row_i = IDX_W'(a);
                it.col_j = IDX_W'(b);
                send_item(it, 1'b0, '0);
            end
        for (int a = 0; a < N_MAX; a++)
        begin
            it       = random_item();
            it.mode  = MODE_LOAD_PLACE;
            it.row_i = IDX_W'(a);
            send_item(it, 1'b0, '0);
        end

        // random phases, one problem size each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_problem_size(sizes[ph], ph == 1);
            idle_on = (ph != NO_IDLE_PHASE);
            if (ph == HOLD_PHASE)
                hold_go = 1'b1;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                if ($urandom_range(99) < 35)
                    send_move_sequence();
                else
                    send_item(random_item(), 1'b0, '0);
            end
        end

        // final drain and verdict
        settle();
        if (errors == 0)
            $display("qap_swap_delta_evaluator verification clean");
        else
            $display("qap_swap_delta_evaluator verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/qsd_pkg.sv
sv/qsd_mem.sv
sv/qsd_mac.sv
sv/qsd_seq.sv
sv/qap_swap_delta_evaluator.sv
tb/sv/tb_qap_swap_delta_evaluator.sv
